[sv/sm4_pkg.sv]
// Shared types, constants and round functions of the SM4 block cipher.
`default_nettype none

package sm4_pkg;

  localparam int WORD_W     = 32;
  localparam int NUM_ROUNDS = 32;
  localparam int RK_IDX_W   = $clog2(NUM_ROUNDS);
  localparam int REG_W      = 64;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } cfg_reg_t;

  // Key schedule states
  typedef enum logic [1:0] {
    KS_IDLE,
    KS_LOAD,
    KS_RUN
  } ks_state_t;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic [REG_W-1:0] block_high;
    logic [REG_W-1:0] block_low;
    logic             decrypt;
  } blk_item_t;

  typedef struct packed {
    logic [REG_W-1:0] result_high;
    logic [REG_W-1:0] result_low;
  } res_item_t;

  // Data handed from one round cell to the next
  typedef struct packed {
    logic  dec;
    word_t x0;
    word_t x1;
    word_t x2;
    word_t x3;
  } stage_t;

  // Round key write broadcast from the key schedule to the cells
  typedef struct packed {
    logic                wr;
    logic [RK_IDX_W-1:0] idx;
    word_t               rk;
  } rk_wr_t;

  localparam word_t FK [4] = '{32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc};

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic word_t rotl32(input word_t x, input int unsigned n);
    return (x << n) | (x >> (WORD_W - n));
  endfunction

  // Substitute all four bytes of a word
  function automatic word_t sbox_word(input word_t x);
    return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  // Linear transform of the data rounds
  function automatic word_t lin_data(input word_t t);
    return t ^ rotl32(t, 2) ^ rotl32(t, 10) ^ rotl32(t, 18) ^ rotl32(t, 24);
  endfunction

  // Linear transform of the key schedule
  function automatic word_t lin_key(input word_t t);
    return t ^ rotl32(t, 13) ^ rotl32(t, 23);
  endfunction

  // CK constant: byte j of word i is (4i+j)*7 mod 256
  function automatic word_t ck_word(input logic [RK_IDX_W-1:0] i);
    word_t      w;
    logic [7:0] base;
    base = {1'b0, i, 2'b00};
    for (int j = 0; j < 4; j++) begin
      w[31-8*j -: 8] = 8'((base + 8'(j)) * 8'd7);
    end
    return w;
  endfunction

endpackage

`default_nettype wire

[sv/sm4_key_sched.sv]
// Key registers and sequential key expansion, one round key per cycle.
`default_nettype none

module sm4_key_sched (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [sm4_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sm4_pkg::REG_W-1:0]        cfg_data,
  output sm4_pkg::rk_wr_t                       ks,
  output logic                                  busy
);

  logic [sm4_pkg::REG_W-1:0]    key_high;
  logic [sm4_pkg::REG_W-1:0]    key_low;
  sm4_pkg::ks_state_t           state;
  sm4_pkg::ks_state_t           state_next;
  sm4_pkg::word_t               k0, k1, k2, k3;
  logic [sm4_pkg::RK_IDX_W-1:0] cnt;
  sm4_pkg::word_t               nk;

  // Key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == sm4_pkg::REG_KEY_HIGH) begin
        key_high <= cfg_data;
      end else begin
        key_low <= cfg_data;
      end
    end
  end

  // Next state: restart expansion on every key write
  always_comb begin
    state_next = state;
    case (state)
      sm4_pkg::KS_IDLE: begin
        if (cfg_we) state_next = sm4_pkg::KS_LOAD;
      end
      sm4_pkg::KS_LOAD: begin
        if (!cfg_we) state_next = sm4_pkg::KS_RUN;
      end
      sm4_pkg::KS_RUN: begin
        if (cfg_we) begin
          state_next = sm4_pkg::KS_LOAD;
        end else if (cnt == sm4_pkg::RK_IDX_W'(sm4_pkg::NUM_ROUNDS - 1)) begin
          state_next = sm4_pkg::KS_IDLE;
        end
      end
      default: state_next = sm4_pkg::KS_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sm4_pkg::KS_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // One key schedule step
  assign nk = k0 ^ sm4_pkg::lin_key(sm4_pkg::sbox_word(k1 ^ k2 ^ k3 ^ sm4_pkg::ck_word(cnt)));

  // Load the masked key, then advance the word window
  always_ff @(posedge clk) begin
    if (state == sm4_pkg::KS_LOAD) begin
      k0  <= key_high[63:32] ^ sm4_pkg::FK[0];
      k1  <= key_high[31:0]  ^ sm4_pkg::FK[1];
      k2  <= key_low[63:32]  ^ sm4_pkg::FK[2];
      k3  <= key_low[31:0]   ^ sm4_pkg::FK[3];
      cnt <= '0;
    end else if (state == sm4_pkg::KS_RUN) begin
      k0  <= k1;
      k1  <= k2;
      k2  <= k3;
      k3  <= nk;
      cnt <= cnt + 1'b1;
    end
  end

  // Outputs
  always_comb begin
    ks.wr  = (state == sm4_pkg::KS_RUN);
    ks.idx = cnt;
    ks.rk  = nk;
    busy   = (state != sm4_pkg::KS_IDLE);
  end

`ifndef SYNTH
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == sm4_pkg::KS_RUN && cnt == sm4_pkg::RK_IDX_W'(sm4_pkg::NUM_ROUNDS - 1) && !cfg_we)
    |=> state == sm4_pkg::KS_IDLE)
    else $error("key expansion did not stop after the last round key");
`endif

endmodule

`default_nettype wire

[sv/sm4_round_cell.sv]
// One SM4 round: holds its two round keys and one in-flight item.
`default_nettype none

module sm4_round_cell (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [sm4_pkg::RK_IDX_W-1:0]   pos,
  input  wire sm4_pkg::rk_wr_t                ks,
  input  wire logic                           up_valid,
  output logic                                up_ready,
  input  wire sm4_pkg::stage_t                up,
  output logic                                dn_valid,
  input  wire logic                           dn_ready,
  output sm4_pkg::stage_t                     dn
);

  logic            valid;
  sm4_pkg::stage_t data;
  sm4_pkg::stage_t data_next;
  sm4_pkg::word_t  rk_enc;
  sm4_pkg::word_t  rk_dec;
  sm4_pkg::word_t  rk;

  // Capture this round's key, and its mirror for decryption
  always_ff @(posedge clk) begin
    if (ks.wr && ks.idx == pos) rk_enc <= ks.rk;
    if (ks.wr && ks.idx == ~pos) rk_dec <= ks.rk;
  end

  // Round function on the incoming words
  assign rk = up.dec ? rk_dec : rk_enc;

  always_comb begin
    data_next.dec = up.dec;
    data_next.x0  = up.x1;
    data_next.x1  = up.x2;
    data_next.x2  = up.x3;
    data_next.x3  = up.x0 ^ sm4_pkg::lin_data(sm4_pkg::sbox_word(up.x1 ^ up.x2 ^ up.x3 ^ rk));
  end

  // Take a new item whenever this cell is empty or its item moves on
  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) data <= data_next;
  end

  assign dn_valid = valid;
  assign dn       = data;

`ifndef SYNTH
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !dn_ready |=> valid && $stable(data))
    else $error("round cell lost or changed a stalled item");
`endif

endmodule

`default_nettype wire

[sv/sm4_block_cipher.sv]
// Top level of the SM4 block cipher: key schedule and a chain of 32 round cells.
//
// Usage:
//   Write the 128-bit key through cfg_we/cfg_index/cfg_data (index 0 holds
//   the upper 64 bits, index 1 the lower 64 bits). Each write starts a key
//   expansion: the key is loaded first, then one round key per cycle comes
//   from the shared key schedule step. blk_ready stays low during
//   expansion. Reset clears the key to zero and runs the same expansion, so
//   blk_ready rises only once that expansion ends.
//   Input items (blk) carry one 128-bit block and the decrypt flag. Each of
//   the 32 round cells applies one round and passes the item on, so one item
//   enters every cycle while res_ready stays high, and a result leaves res
//   after passing through all 32 cells; the last cell is the output register.
//   When res_ready is low the last cell holds its result; earlier cells
//   keep moving until they close up behind it, and blk_ready drops only
//   once the first cell is full and cannot advance.
`default_nettype none

module sm4_block_cipher (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [sm4_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sm4_pkg::REG_W-1:0]      cfg_data,
  input  wire logic                           blk_valid,
  output logic                                blk_ready,
  input  wire sm4_pkg::blk_item_t             blk,
  output logic                                res_valid,
  input  wire logic                           res_ready,
  output sm4_pkg::res_item_t                  res
);

  sm4_pkg::rk_wr_t ks;
  logic            busy;
  logic            head_valid;
  sm4_pkg::stage_t head;

  logic            cell_valid [sm4_pkg::NUM_ROUNDS];
  logic            cell_ready [sm4_pkg::NUM_ROUNDS];
  sm4_pkg::stage_t cell_data  [sm4_pkg::NUM_ROUNDS];

  sm4_key_sched u_key_sched (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ks        (ks),
    .busy      (busy)
  );

  // Split the input block into words for the first round
  always_comb begin
    head.dec = blk.decrypt;
    head.x0  = blk.block_high[63:32];
    head.x1  = blk.block_high[31:0];
    head.x2  = blk.block_low[63:32];
    head.x3  = blk.block_low[31:0];
  end

  assign head_valid = blk_valid && !busy;
  assign blk_ready  = cell_ready[0] && !busy;

  // Chain of round cells
  for (genvar i = 0; i < sm4_pkg::NUM_ROUNDS; i++) begin : g_cell
    logic            up_valid;
    sm4_pkg::stage_t up;
    logic            dn_ready;

    if (i == 0) begin : g_first
      assign up_valid = head_valid;
      assign up       = head;
    end else begin : g_next
      assign up_valid = cell_valid[i-1];
      assign up       = cell_data[i-1];
    end

    if (i == sm4_pkg::NUM_ROUNDS - 1) begin : g_last
      assign dn_ready = res_ready;
    end else begin : g_mid
      assign dn_ready = cell_ready[i+1];
    end

    sm4_round_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .pos      (sm4_pkg::RK_IDX_W'(i)),
      .ks       (ks),
      .up_valid (up_valid),
      .up_ready (cell_ready[i]),
      .up       (up),
      .dn_valid (cell_valid[i]),
      .dn_ready (dn_ready),
      .dn       (cell_data[i])
    );
  end

  // Final word reversal
  assign res_valid       = cell_valid[sm4_pkg::NUM_ROUNDS-1];
  assign res.result_high = {cell_data[sm4_pkg::NUM_ROUNDS-1].x3,
                            cell_data[sm4_pkg::NUM_ROUNDS-1].x2};
  assign res.result_low  = {cell_data[sm4_pkg::NUM_ROUNDS-1].x1,
                            cell_data[sm4_pkg::NUM_ROUNDS-1].x0};

`ifndef SYNTH
  a_enter: assert property (@(posedge clk) disable iff (rst)
    blk_valid && blk_ready |=> cell_valid[0])
    else $error("accepted item did not enter the first round cell");

  a_no_dup: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !cell_valid[sm4_pkg::NUM_ROUNDS-2] |=> !res_valid)
    else $error("result item repeated after it was taken");
`endif

endmodule

`default_nettype wire

[tb/sm4_block_cipher_test.sv]
// Self-checking testbench for the SM4 block cipher: directed vectors, then random blocks.
module sm4_block_cipher_test;

  localparam int EXPAND_CYCLES = 40;
  localparam int DRAIN_CYCLES  = 40;        // pipeline depth is 32 cells
  localparam int TIMEOUT_TIME  = 2_000_000;

  localparam logic [31:0] FK_WORDS [4] = '{
    32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
  };

  localparam logic [7:0] SBOX_BYTES [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  // Standard test vector of GB/T 32907
  localparam logic [127:0] STD_KEY    = 128'h0123456789abcdeffedcba9876543210;
  localparam logic [127:0] STD_CIPHER = 128'h681edf34d206965e86b3e94f536e4246;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [sm4_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sm4_pkg::REG_W-1:0]     cfg_data;
  logic                          blk_valid;
  logic                          blk_ready;
  sm4_pkg::blk_item_t            blk;
  logic                          res_valid;
  logic                          res_ready;
  sm4_pkg::res_item_t            res;

  // Key registers and expanded round keys as the block should hold them
  logic [63:0]                   key_high;
  logic [63:0]                   key_low;
  logic [31:0]                   sched_words [32];
  sm4_pkg::res_item_t            pending_results [$];
  int                            error_count;
  bit                            idle_en;

  sm4_block_cipher i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .blk_valid (blk_valid),
    .blk_ready (blk_ready),
    .blk       (blk),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] sub_bytes(input logic [31:0] x);
    return {SBOX_BYTES[x[31:24]], SBOX_BYTES[x[23:16]], SBOX_BYTES[x[15:8]],
            SBOX_BYTES[x[7:0]]};
  endfunction

  // Rebuild the 32 round keys from the current key registers
  function automatic void expand_sched_words();
    logic [31:0] k [4];
    logic [31:0] ck;
    logic [31:0] t;
    logic [31:0] nk;
    k[0] = key_high[63:32] ^ FK_WORDS[0];
    k[1] = key_high[31:0]  ^ FK_WORDS[1];
    k[2] = key_low[63:32]  ^ FK_WORDS[2];
    k[3] = key_low[31:0]   ^ FK_WORDS[3];
    for (int i = 0; i < 32; i++) begin
      for (int j = 0; j < 4; j++) begin
        ck[31-8*j -: 8] = 8'(((4 * i + j) * 7) & 255);
      end
      t  = sub_bytes(k[1] ^ k[2] ^ k[3] ^ ck);
      nk = k[0] ^ t ^ rol32(t, 13) ^ rol32(t, 23);
      k[0] = k[1];
      k[1] = k[2];
      k[2] = k[3];
      k[3] = nk;
      sched_words[i] = nk;
    end
  endfunction

  // Run the 32 rounds and the final word reversal on one block
  function automatic sm4_pkg::res_item_t cipher_block(input sm4_pkg::blk_item_t item);
    logic [31:0]        x [4];
    logic [31:0]        t;
    logic [31:0]        nx;
    sm4_pkg::res_item_t r;
    x[0] = item.block_high[63:32];
    x[1] = item.block_high[31:0];
    x[2] = item.block_low[63:32];
    x[3] = item.block_low[31:0];
    for (int i = 0; i < 32; i++) begin
      t  = sub_bytes(x[1] ^ x[2] ^ x[3] ^ sched_words[item.decrypt ? 31 - i : i]);
      nx = x[0] ^ t ^ rol32(t, 2) ^ rol32(t, 10) ^ rol32(t, 18) ^ rol32(t, 24);
      x[0] = x[1];
      x[1] = x[2];
      x[2] = x[3];
      x[3] = nx;
    end
    r.result_high = {x[3], x[2]};
    r.result_low  = {x[1], x[0]};
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic sm4_pkg::blk_item_t random_block();
    sm4_pkg::blk_item_t item;
    item.block_high = rand64();
    item.block_low  = rand64();
    item.decrypt    = 1'($urandom_range(1));
    return item;
  endfunction

  function automatic sm4_pkg::blk_item_t make_block(input logic [127:0] data,
                                                    input logic dec);
    sm4_pkg::blk_item_t item;
    item.block_high = data[127:64];
    item.block_low  = data[63:0];
    item.decrypt    = dec;
    return item;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR %s", $time, msg);
    error_count++;
  endtask

  // Offer one item (after random idling if idle_en is set), hold it until accepted, then record its expected result
  task automatic send_block(input sm4_pkg::blk_item_t item);
    while (idle_en && $urandom_range(99) < 26) begin
      blk_valid <= 1'b0;
      @(posedge clk);
    end
    blk_valid <= 1'b1;
    blk       <= item;
    @(posedge clk);
    while (!blk_ready) @(posedge clk);
    pending_results.insert(pending_results.size(), cipher_block(item));
  endtask

  // Stop sending and wait until every expected result has come out
  task automatic drain_results();
    blk_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write one key register while idle, then let the expansion finish
  task automatic write_key_reg(input sm4_pkg::cfg_reg_t idx, input logic [63:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sm4_pkg::REG_KEY_HIGH) begin
      key_high = value;
    end else begin
      key_low = value;
    end
    expand_sched_words();
    repeat (EXPAND_CYCLES) @(posedge clk);
  endtask

  task automatic write_key(input logic [127:0] key);
    write_key_reg(sm4_pkg::REG_KEY_HIGH, key[127:64]);
    write_key_reg(sm4_pkg::REG_KEY_LOW, key[63:0]);
  endtask

  // All-zero key from reset, with extreme blocks both ways
  task automatic test_reset_key();
    send_block(make_block('0, 1'b0));
    send_block(make_block('1, 1'b0));
    send_block(make_block('0, 1'b1));
    send_block(make_block('1, 1'b1));
  endtask

  // Standard vector: encrypt the plaintext, decrypt the ciphertext
  task automatic test_known_answer();
    sm4_pkg::res_item_t r;
    write_key(STD_KEY);
    r = cipher_block(make_block(STD_KEY, 1'b0));
    if ({r.result_high, r.result_low} !== STD_CIPHER) begin
      report_mismatch($sformatf("key schedule or rounds off: vector gives %h",
                                {r.result_high, r.result_low}));
    end
    send_block(make_block(STD_KEY, 1'b0));
    send_block(make_block(STD_CIPHER, 1'b1));
  endtask

  // All-ones key with extreme blocks
  task automatic test_all_ones_key();
    write_key('1);
    send_block(make_block('0, 1'b0));
    send_block(make_block('1, 1'b0));
    send_block(make_block('0, 1'b1));
    send_block(make_block('1, 1'b1));
  endtask

  // A write of one register alone must take effect for the blocks after it
  task automatic test_single_register();
    write_key_reg(sm4_pkg::REG_KEY_LOW, 64'h0);
    send_block(random_block());
    send_block(random_block());
    write_key_reg(sm4_pkg::REG_KEY_HIGH, 64'h8000_0000_0000_0001);
    send_block(random_block());
    send_block(random_block());
  endtask

  // Random blocks in phases with different keys and idling styles
  task automatic test_random_traffic();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1: begin
          write_key({64'hffff_ffff_ffff_ffff, 64'h0});
        end
        3: begin
          write_key('0);
        end
        default: begin
          write_key({rand64(), rand64()});
        end
      endcase
      // one phase runs with no idling on either side
      idle_en = (phase != 2);
      for (int n = 0; n < 100; n++) begin
        send_block(random_block());
        if ($urandom_range(39) == 0) drain_results();
      end
    end
    idle_en = 1'b1;
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    sm4_pkg::res_item_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with none expected: %h %h",
                                  res.result_high, res.result_low));
      end else begin
        want = pending_results.pop_front();
        if (res.result_high !== want.result_high) begin
          report_mismatch($sformatf("result_high got %h want %h",
                                    res.result_high, want.result_high));
        end
        if (res.result_low !== want.result_low) begin
          report_mismatch($sformatf("result_low got %h want %h",
                                    res.result_low, want.result_low));
        end
      end
    end
  end

  // Stall the result side at random while idle_en is set
  always @(posedge clk) begin
    res_ready <= !idle_en || ($urandom_range(99) >= 26);
  end

  initial begin
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = sm4_pkg::REG_KEY_HIGH;
    cfg_data    = '0;
    blk_valid   = 1'b0;
    blk         = '0;
    res_ready   = 1'b0;
    idle_en     = 1'b1;
    error_count = 0;
    key_high    = '0;
    key_low     = '0;
    expand_sched_words();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_key();
    test_known_answer();
    test_all_ones_key();
    test_single_register();
    test_random_traffic();

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #TIMEOUT_TIME;
    $display("FAILURE");
    $finish;
  end

endmodule

[sim.f]
sv/sm4_pkg.sv
sv/sm4_key_sched.sv
sv/sm4_round_cell.sv
sv/sm4_block_cipher.sv
tb/sm4_block_cipher_test.sv
